>>> rtl/core/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg
// Shared item types for the point to line distance pipeline.
// ----------------------------------------------------------------------------
package pld_pkg;

	localparam int CW = 16;
	localparam int DW = 24;

	typedef struct packed {
		logic signed [CW-1:0] coef_a;
		logic signed [CW-1:0] coef_b;
		logic signed [CW-1:0] coef_c;
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
	} pld_in_t;

	typedef struct packed {
		logic [DW-1:0] distance;
		logic          degenerate;
		logic          saturated;
	} pld_out_t;

endpackage

>>> rtl/core/point_line_distance.sv
// ----------------------------------------------------------------------------
// point_line_distance
// Distance from a point to a line a*x+b*y+c=0, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One item is accepted per cycle (busy is always low) and its result appears
// on res for one cycle with res_valid high, after passing the product, sum,
// root, divider and output stages. The root yields one result bit per stage
// and the restoring divider one quotient bit per stage. The receiver cannot
// stall: every result must be taken as it shows.
module point_line_distance
	import pld_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pld_in_t  item,
	output logic     res_valid,
	output pld_out_t res
);

	localparam int F  = 8;
	localparam int NW = 2*CW + 2;       // numerator magnitude bits
	localparam int SW = 2*CW;           // a*a+b*b bits
	localparam int SQ = CW;             // root bits
	localparam int QB = NW;             // quotient bits
	localparam logic [DW-1:0] MAXC = '1;

	assign busy = 1'b0;

	// stage 1: products
	logic               v_s1, dg_s1;
	logic signed [SW:0] ax_s1, by_s1, c_s1;
	logic [SW-1:0]      aa_s1, bb_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		ax_s1 <= (SW+1)'((SW+1)'(item.coef_a) * (SW+1)'(item.point_x));
		by_s1 <= (SW+1)'((SW+1)'(item.coef_b) * (SW+1)'(item.point_y));
		c_s1  <= (SW+1)'(item.coef_c) <<< F;
		aa_s1 <= SW'(SW'(item.coef_a) * SW'(item.coef_a));
		bb_s1 <= SW'(SW'(item.coef_b) * SW'(item.coef_b));
		dg_s1 <= (item.coef_a == '0) && (item.coef_b == '0);
	end

	// stage 2: sums and magnitude
	logic            v_s2, dg_s2;
	logic [NW-1:0]   num_s2;
	logic [SW:0]     rad_s2;
	logic signed [NW:0] tot;
	always_comb tot = (NW+1)'(ax_s1) + (NW+1)'(by_s1) + (NW+1)'(c_s1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		num_s2 <= tot[NW] ? NW'(-tot) : NW'(tot);
		rad_s2 <= (SW+1)'(aa_s1) + (SW+1)'(bb_s1);
		dg_s2  <= dg_s1;
	end

	// root stages: one result bit each, msb first
	localparam int RW = SW + 2;
	logic [SQ:0]      rv;
	logic [SQ:0]      rdg;
	logic [RW-1:0]    rrem [SQ+1];
	logic [SQ-1:0]    rroot[SQ+1];
	logic [SW:0]      rrad [SQ+1];
	logic [NW-1:0]    rnum [SQ+1];
	assign rv[0] = v_s2;
	assign rdg[0] = dg_s2;
	assign rrem[0] = '0;
	assign rroot[0] = '0;
	assign rrad[0] = rad_s2;
	assign rnum[0] = num_s2;
	for (genvar i = 0; i < SQ; i++) begin : g_root
		logic [RW-1:0] r2, trial;
		// radicand never reaches its top bit, pairs start one bit below it
		always_comb begin
			r2 = {rrem[i][RW-3:0], rrad[i][SW-1:SW-2]};
			trial = {rroot[i], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv[i+1] <= 1'b0;
			else rv[i+1] <= rv[i];
		end
		always_ff @(posedge clk) begin
			if (r2 >= trial) begin
				rrem[i+1] <= r2 - trial;
				rroot[i+1] <= {rroot[i][SQ-2:0], 1'b1};
			end else begin
				rrem[i+1] <= r2;
				rroot[i+1] <= {rroot[i][SQ-2:0], 1'b0};
			end
			rrad[i+1] <= {rrad[i][SW-2:0], 2'b00};
			rnum[i+1] <= rnum[i];
			rdg[i+1] <= rdg[i];
		end
	end

	// divider stages: one quotient bit each, msb first
	logic [QB:0]    dv, ddg;
	logic [SQ:0]    drem [QB+1];
	logic [NW-1:0]  dnum [QB+1];
	logic [SQ-1:0]  dden [QB+1];
	assign dv[0] = rv[SQ];
	assign ddg[0] = rdg[SQ];
	assign drem[0] = '0;
	assign dnum[0] = rnum[SQ];
	assign dden[0] = rroot[SQ];
	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [SQ+1:0] sh;
		always_comb sh = {drem[j], dnum[j][NW-1]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[j+1] <= 1'b0;
			else dv[j+1] <= dv[j];
		end
		always_ff @(posedge clk) begin
			if (sh >= {2'b00, dden[j]}) begin
				drem[j+1] <= (SQ+1)'(sh - {2'b00, dden[j]});
				dnum[j+1] <= {dnum[j][NW-2:0], 1'b1};
			end else begin
				drem[j+1] <= (SQ+1)'(sh);
				dnum[j+1] <= {dnum[j][NW-2:0], 1'b0};
			end
			dden[j+1] <= dden[j];
			ddg[j+1] <= ddg[j];
		end
	end

	// output stage: saturation and degenerate case
	logic [QB-1:0] q;
	assign q = dnum[QB];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else res_valid <= dv[QB];
	end
	always_ff @(posedge clk) begin
		if (ddg[QB]) begin
			res.distance <= '0;
			res.degenerate <= 1'b1;
			res.saturated <= 1'b0;
		end else if (q[QB-1:DW] != '0) begin
			res.distance <= MAXC;
			res.degenerate <= 1'b0;
			res.saturated <= 1'b1;
		end else begin
			res.distance <= q[DW-1:0];
			res.degenerate <= 1'b0;
			res.saturated <= 1'b0;
		end
	end

endmodule
